// File: rtl/icc_pkg.sv
// shared types, constants and helpers of the interrupt controller
package icc_pkg;

	localparam int DATA_W      = 32;
	localparam int NUM_SOURCES = 32;
	localparam int SRC_IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

	// sources that exist, and the enable bits that can be set (source 0 never)
	localparam logic [DATA_W-1:0] SRC_MASK =
		DATA_W'({DATA_W{1'b1}} >> (DATA_W - NUM_SOURCES));
	localparam logic [DATA_W-1:0] ENABLE_MASK = SRC_MASK & ~DATA_W'(1);

	// actions
	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_WRITE  = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// register map
	localparam logic [2:0] REG_PENDING   = 3'd0;
	localparam logic [2:0] REG_ENABLE    = 3'd1;
	localparam logic [2:0] REG_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_CLAIM     = 3'd3;
	localparam logic [2:0] REG_UNMAPPED  = 3'd4;  // first of the unmapped indexes

	typedef struct packed {
		logic [1:0]        action;
		logic [2:0]        reg_select;
		logic [DATA_W-1:0] write_data;
		logic [DATA_W-1:0] active_lines;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              ext_irq;
	} result_t;

	// index of the highest set bit among the existing sources
	function automatic logic [SRC_IDX_W-1:0] top_index(input logic [DATA_W-1:0] v);
		logic [SRC_IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (v[i]) begin
				idx = SRC_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: rtl/icc_if.sv
// handshake channels of the interrupt controller: request and response words
interface icc_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic [2:0]                  reg_select;
	logic [icc_pkg::DATA_W-1:0]  write_data;
	logic [icc_pkg::DATA_W-1:0]  active_lines;

	modport source (output valid, action, reg_select, write_data, active_lines, input ready);
	modport sink   (input valid, action, reg_select, write_data, active_lines, output ready);
endinterface

interface icc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [icc_pkg::DATA_W-1:0]  read_data;
	logic                        ext_irq;

	modport source (output valid, read_data, ext_irq, input ready);
	modport sink   (input valid, read_data, ext_irq, output ready);
endinterface

// File: rtl/interrupt_controller_claim_complete.sv
// top level of the single-target interrupt controller with claim and complete
// usage:
//   req channel carries one word per update tick or bus access: action
//   (update, read, write), reg_select, write_data and the active source lines
//   rsp channel returns exactly one word per request, in order: read_data
//   (register value, claimed source index, or zero) and ext_irq, the
//   external interrupt level as left by the most recent update
// path: a request accepted sits in the input register, and its response is
//   loaded into the response register, and valid, when the word moves on
// throughput: one word per cycle unless rsp stalls; a word updates state
//   as it leaves the input register, so each sees the effect of the one before
// stall: when rsp.ready is low the response register holds its word, the
//   input register keeps one more word, and req.ready drops only when both
//   are full; nothing is dropped or repeated
// reset: arst_n low clears pending, enable and mask bits, the irq level and
//   both valid flags; no clearing pass, requests are taken right after reset
module interrupt_controller_claim_complete (
	input logic          clk,
	input logic          arst_n,
	icc_req_if.sink      req,
	icc_rsp_if.source    rsp
);

	// input register
	logic             valid_s1;
	icc_pkg::item_t   item_s1;

	// response register
	logic             rsp_valid_q;
	icc_pkg::result_t rsp_word_q;

	logic             advance;
	icc_pkg::result_t result;

	// the word in the input register moves on when the response slot is free
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.action       <= req.action;
			item_s1.reg_select   <= req.reg_select;
			item_s1.write_data   <= req.write_data;
			item_s1.active_lines <= req.active_lines;
		end
	end

	icc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp.ready) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_word_q <= result;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_word_q.read_data;
	assign rsp.ext_irq   = rsp_word_q.ext_irq;

`ifndef NO_ASSERTIONS
	// a word held in the input register is not lost while the output stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input word lost during stall");

	// a taken response is replaced only by the word that moved on
	a_rsp_refill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp.ready |=> rsp_valid_q == $past(valid_s1))
		else $error("response register refilled wrongly");

	// request side backs up only when both registers are full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && rsp_valid_q && !rsp.ready)
		else $error("request stalled with free space");
`endif

endmodule

// File: rtl/icc_core.sv
// interrupt state and the per-word update, read and claim logic
module icc_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_en,
	input  icc_pkg::item_t  item,
	output icc_pkg::result_t result
);

	logic [icc_pkg::DATA_W-1:0] pending_q, enable_q, masked_q;
	logic                       irq_q;

	logic [icc_pkg::DATA_W-1:0] pending_d, enable_d, masked_d;
	logic                       irq_d;
	logic [icc_pkg::DATA_W-1:0] lines, cand, claim_bit, done_bit;
	logic [icc_pkg::SRC_IDX_W-1:0] claim_idx;
	logic [icc_pkg::DATA_W-1:0] rdata;

	assign lines     = item.active_lines & icc_pkg::SRC_MASK;
	assign cand      = pending_q & enable_q;
	assign claim_idx = icc_pkg::top_index(cand);
	assign claim_bit = icc_pkg::DATA_W'(1) << claim_idx;
	assign done_bit  = icc_pkg::DATA_W'(1) << item.write_data[icc_pkg::SRC_IDX_W-1:0];

	always_comb begin
		pending_d = pending_q;
		enable_d  = enable_q;
		masked_d  = masked_q;
		irq_d     = irq_q;
		rdata     = '0;
		unique case (item.action)
			icc_pkg::ACT_UPDATE: begin
				pending_d = pending_q | (lines & ~masked_q);
				masked_d  = masked_q | lines;
				irq_d     = |(pending_d & enable_q);
			end
			icc_pkg::ACT_READ: begin
				unique case (item.reg_select)
					icc_pkg::REG_PENDING: rdata = pending_q;
					icc_pkg::REG_ENABLE:  rdata = enable_q;
					icc_pkg::REG_CLAIM: begin
						if (|cand) begin
							rdata     = icc_pkg::DATA_W'(claim_idx);
							pending_d = pending_q & ~claim_bit;
						end
					end
					default: rdata = '0; // threshold reads zero, unmapped too
				endcase
			end
			icc_pkg::ACT_WRITE: begin
				unique case (item.reg_select)
					icc_pkg::REG_ENABLE: enable_d = item.write_data & icc_pkg::ENABLE_MASK;
					icc_pkg::REG_CLAIM: begin
						if (item.write_data < icc_pkg::DATA_W'(icc_pkg::NUM_SOURCES)
								&& |(enable_q & done_bit)) begin
							masked_d = masked_q & ~done_bit;
						end
					end
					default: ; // pending, threshold and unmapped writes dropped
				endcase
			end
			default: ; // unused action
		endcase
	end

	assign result.read_data = rdata;
	assign result.ext_irq   = irq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			enable_q  <= '0;
			masked_q  <= '0;
			irq_q     <= 1'b0;
		end else if (step_en) begin
			pending_q <= pending_d;
			enable_q  <= enable_d;
			masked_q  <= masked_d;
			irq_q     <= irq_d;
		end
	end

`ifndef NO_ASSERTIONS
	// source 0 and absent sources can never be enabled
	a_enable_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(enable_q & ~icc_pkg::ENABLE_MASK) == '0)
		else $error("enable bit set outside legal sources");

	// only an update word moves the interrupt level
	a_irq_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(step_en && item.action == icc_pkg::ACT_UPDATE) |=> $stable(irq_q))
		else $error("irq level changed without update");

	// pending bits are raised only by an update word
	a_pending_raise: assert property (@(posedge clk) disable iff (!arst_n)
		!(step_en && item.action == icc_pkg::ACT_UPDATE)
		|=> (pending_q & ~$past(pending_q)) == '0)
		else $error("pending bit raised without update");

	// a newly pending source is masked at the same time
	a_pending_masked: assert property (@(posedge clk) disable iff (!arst_n)
		((pending_q & ~$past(pending_q)) & ~masked_q) == '0)
		else $error("new pending source not masked");
`endif

endmodule
